// ----- hdl/ppbm_pkg.sv -----
// Package for the ping-pong buffer manager: operation codes, the result word
// type and the field widths shared by the engine, output register and top level.
// No dependencies.
`default_nettype none

package ppbm_pkg;

    localparam int SLOT_W = 7;
    localparam int OP_W   = 2;

    localparam logic [SLOT_W-1:0] FPP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] write_slot;
        logic              write_valid;
        logic              handoff_valid;
        logic              handoff_page;
        logic              pull_ready;
        logic              pull_page;
        logic [SLOT_W-1:0] pull_offset;
        logic [SLOT_W-1:0] pull_length;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/ppbm_if.sv -----
// Channel interfaces of the ping-pong buffer manager: request, response and
// configuration write. Depends on ppbm_pkg.
`default_nettype none

interface ppbm_req_if;
    import ppbm_pkg::*;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] op;
    logic            page_id;

    modport source (output valid, output op, output page_id, input ready);
    modport sink   (input valid, input op, input page_id, output ready);
endinterface

interface ppbm_rsp_if;
    import ppbm_pkg::*;
    logic              valid;
    logic              ready;
    logic              status;
    logic [SLOT_W-1:0] write_slot;
    logic              write_valid;
    logic              handoff_valid;
    logic              handoff_page;
    logic              pull_ready;
    logic              pull_page;
    logic [SLOT_W-1:0] pull_offset;
    logic [SLOT_W-1:0] pull_length;

    modport source (output valid, output status, output write_slot, output write_valid,
                    output handoff_valid, output handoff_page, output pull_ready,
                    output pull_page, output pull_offset, output pull_length,
                    input ready);
    modport sink   (input valid, input status, input write_slot, input write_valid,
                    input handoff_valid, input handoff_page, input pull_ready,
                    input pull_page, input pull_offset, input pull_length,
                    output ready);
endinterface

interface ppbm_cfg_if;
    import ppbm_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ppbm_engine.sv -----
// Page state of the ping-pong buffer manager (two fill counters, current page,
// page size register) and the combinational next-state / result logic.
// Depends on ppbm_pkg.
`default_nettype none

module ppbm_engine
    import ppbm_pkg::*;
#(
    parameter int MAX_FRAMES = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [SLOT_W-1:0] cfg_data,
    input  wire logic              accept,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic              page_id,
    output result_t                result
);

    logic [SLOT_W-1:0] fpp_reg;
    logic [SLOT_W-1:0] fill_reg [2];
    logic [SLOT_W-1:0] fill_next [2];
    logic              cur_reg;
    logic              cur_next;
    logic [SLOT_W-1:0] size;
    logic              full0;
    logic              full1;
    logic              cur_full;
    logic              r0;
    logic              r1;
    logic              pp;

    // effective size: 0 acts as 1, anything past MAX_FRAMES is clamped
    always_comb
    begin
        if (fpp_reg == '0)
            size = SLOT_W'(1);
        else if (int'(fpp_reg) > MAX_FRAMES)
            size = SLOT_W'(MAX_FRAMES);
        else
            size = fpp_reg;
    end

    assign full0    = (fill_reg[0] >= size);
    assign full1    = (fill_reg[1] >= size);
    assign cur_full = cur_reg ? full1 : full0;

    always_comb
    begin
        fill_next[0] = fill_reg[0];
        fill_next[1] = fill_reg[1];
        cur_next     = cur_reg;
        result       = '0;
        case (op_t'(op))
            OP_PUSH:
            begin
                if (full0 && full1)
                begin
                    result.status = 1'b1;
                end
                else
                begin
                    if (cur_full)
                    begin
                        result.handoff_valid = 1'b1;
                        result.handoff_page  = cur_reg;
                        cur_next             = ~cur_reg;
                    end
                    result.write_valid   = 1'b1;
                    result.write_slot    = (cur_next ? size : '0) + fill_reg[cur_next];
                    fill_next[cur_next]  = fill_reg[cur_next] + SLOT_W'(1);
                end
            end
            OP_RELEASE:
            begin
                fill_next[page_id] = '0;
            end
            OP_CLEAR:
            begin
                fill_next[0] = '0;
                fill_next[1] = '0;
                cur_next     = 1'b0;
            end
            default:
            begin
            end
        endcase

        // pull report on the state after this word
        r0 = (fill_next[0] >= size);
        r1 = (fill_next[1] >= size);
        pp = (r0 && r1) ? ~cur_next : r1;
        if (r0 || r1)
        begin
            result.pull_ready  = 1'b1;
            result.pull_page   = pp;
            result.pull_offset = pp ? size : '0;
            result.pull_length = size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpp_reg     <= FPP_RESET;
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
            cur_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fpp_reg <= cfg_data;
            if (accept)
            begin
                fill_reg[0] <= fill_next[0];
                fill_reg[1] <= fill_next[1];
                cur_reg     <= cur_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ppbm_out_reg.sv -----
// Result register of the ping-pong buffer manager: holds one result word and
// takes the next one in the same cycle the held word is taken. Depends on ppbm_pkg.
`default_nettype none

module ppbm_out_reg
    import ppbm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load_valid,
    output logic         load_ready,
    input  wire result_t load_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ready)
            valid_next = load_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/ping_pong_buffer_manager.sv -----
// Ping-pong buffer manager: one request word (push, release, clear) in each cycle the
// result register can take it, one result word out per request in the cycle after.
// The result register lets a new request enter in the same cycle the previous result
// is taken, so with the sink always ready the block sustains one word per clock; the
// rate is set by the single state update of the two fill counters and the page bit
// per cycle. The user must write the page size register through cfg only while it is
// idle; the block does not enforce this. cfg is always ready. Slot addresses are
// page * size + fill, 7 bits wide. Depends on ppbm_pkg, ppbm_if, ppbm_engine, ppbm_out_reg.
`default_nettype none

module ping_pong_buffer_manager
    import ppbm_pkg::*;
#(
    parameter int MAX_FRAMES = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ppbm_cfg_if.sink  cfg,
    ppbm_req_if.sink  req,
    ppbm_rsp_if.source rsp
);

    result_t step_result;
    result_t held_result;
    logic    req_ready;

    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    ppbm_engine #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.data),
        .accept   (req.valid && req_ready),
        .op       (req.op),
        .page_id  (req.page_id),
        .result   (step_result)
    );

    ppbm_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (req.valid),
        .load_ready (req_ready),
        .load_data  (step_result),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_data   (held_result)
    );

    assign rsp.status        = held_result.status;
    assign rsp.write_slot    = held_result.write_slot;
    assign rsp.write_valid   = held_result.write_valid;
    assign rsp.handoff_valid = held_result.handoff_valid;
    assign rsp.handoff_page  = held_result.handoff_page;
    assign rsp.pull_ready    = held_result.pull_ready;
    assign rsp.pull_page     = held_result.pull_page;
    assign rsp.pull_offset   = held_result.pull_offset;
    assign rsp.pull_length   = held_result.pull_length;

endmodule

`default_nettype wire

// ----- hdl/ppbm_checker.sv -----
// Port-level checks for the ping-pong buffer manager and the bind that attaches
// them to the top level. Depends on ppbm_pkg and ping_pong_buffer_manager.
`default_nettype none

module ppbm_checker
    import ppbm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic              status,
    input wire logic              write_valid,
    input wire logic [SLOT_W-1:0] write_slot,
    input wire logic              handoff_valid,
    input wire logic              pull_ready,
    input wire logic              pull_page,
    input wire logic [SLOT_W-1:0] pull_offset,
    input wire logic [SLOT_W-1:0] pull_length
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(write_slot) && $stable(status)
            && $stable(pull_offset))
        else $error("result word changed while stalled");

    a_drop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> !write_valid && !handoff_valid && write_slot == '0)
        else $error("dropped push reports a write");

    a_handoff_writes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && handoff_valid |-> write_valid && !status)
        else $error("handoff without a write");

    a_pull_offset: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && pull_ready |-> pull_length != '0
            && ((!pull_page && pull_offset == '0) || (pull_page && pull_offset == pull_length)))
        else $error("pull offset does not match page and size");

    a_pull_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !pull_ready |-> !pull_page && pull_offset == '0 && pull_length == '0)
        else $error("pull fields set without a ready page");

endmodule

bind ping_pong_buffer_manager ppbm_checker u_ppbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .write_valid   (rsp.write_valid),
    .write_slot    (rsp.write_slot),
    .handoff_valid (rsp.handoff_valid),
    .pull_ready    (rsp.pull_ready),
    .pull_page     (rsp.pull_page),
    .pull_offset   (rsp.pull_offset),
    .pull_length   (rsp.pull_length)
);

`default_nettype wire
